@@ hdl/bevg_pkg.sv @@
// ----------------------------------------------------------------------------
// bevg_pkg
// Shared types and constants of the button event generator: event codes,
// register indexes, threshold settings and the per-button event summary.
// ----------------------------------------------------------------------------
package bevg_pkg;

   // Default geometry
   localparam int BEVG_NUM_BUTTONS = 7;
   localparam int BEVG_TIME_BITS   = 32;

   // Reset values of the settings registers
   localparam logic [6:0]  RST_REPEAT_BUTTONS = 7'd15;
   localparam logic [15:0] RST_START_DELAY    = 16'd500;
   localparam logic [15:0] RST_REPEAT_PERIOD  = 16'd200;
   localparam logic [15:0] RST_LONG_TIME      = 16'd1000;

   // Input function codes
   localparam logic FUNC_POLL   = 1'b0;
   localparam logic FUNC_RESYNC = 1'b1;

   // Event codes on the result channel
   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_REPEAT  = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } ev_kind_type;

   // Settings register indexes
   typedef enum logic [1:0] {
      CSR_REPEAT_BUTTONS = 2'd0,
      CSR_START_DELAY    = 2'd1,
      CSR_REPEAT_PERIOD  = 2'd2,
      CSR_LONG_TIME      = 2'd3
   } csr_index_type;

   // Timing thresholds seen by every button
   typedef struct packed {
      logic [15:0] start_delay;
      logic [15:0] period;
      logic [15:0] long_time;
   } thr_cfg_type;

   // What one button reports for the item under evaluation
   typedef struct packed {
      logic        fire;
      logic        activity;
      ev_kind_type kind;
   } btn_evt_type;

endpackage

@@ hdl/button_event_generator_core.sv @@
// ----------------------------------------------------------------------------
// button_event_generator_core
// Key auto-repeat and long-press detector: turns polled button levels into
// press, repeat, long-press and release events, one beat per event.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | func, pressed_now, now_ms
//   rsp     | out       | rsp_valid/rsp_ready  | event, index, kind, idle, last
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// An item is held in the input register, where all buttons are
// evaluated at once, then moves to the result register as an event mask.
// The result register emits max(1, events) beats, one per cycle unless rsp
// stalls; that sets the rate, and the next item is accepted while it drains.
// Reset clears the valid, activity and button state; no clearing pass is needed.
// A stalled rsp holds the result register and, behind it, the input register.
// ----------------------------------------------------------------------------
module button_event_generator_core #(
   parameter int NUM_BUTTONS = bevg_pkg::BEVG_NUM_BUTTONS,
   parameter int TIME_BITS   = bevg_pkg::BEVG_TIME_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [6:0]  req_pressed_now,
   input  logic [31:0] req_now_ms,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_event,
   output logic [2:0]  rsp_button_index,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_idle_time,
   output logic        rsp_last,
   // Settings port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bevg_pkg::*;

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // Settings registers
   logic [6:0]  rep_buttons_ff;
   thr_cfg_type cfg_ff;

   // Input register
   logic                   in_valid_ff;
   logic                   in_func_ff;
   logic [NUM_BUTTONS-1:0] in_levels_ff;
   logic [TIME_BITS-1:0]   in_now_ff;

   // Shared activity time
   logic [TIME_BITS-1:0]   last_act_ff, last_act_in;

   // Result register
   logic                   busy_ff,  busy_in;
   logic [NUM_BUTTONS-1:0] mask_ff,  mask_in;
   ev_kind_type            kind_ff [NUM_BUTTONS];
   logic [31:0]            idle_ff;

   // Evaluation signals
   btn_evt_type            evt [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] fire_vec, act_vec, rep_mask;
   logic                   poll, move, batch_free, rsp_fire;
   logic [TIME_BITS-1:0]   idle_calc;

   // Serializer signals
   logic [NUM_BUTTONS-1:0] first_hot, mask_rest;
   logic [IDX_W-1:0]       sel_idx;
   ev_kind_type            sel_kind;

   // Write settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_buttons_ff     <= RST_REPEAT_BUTTONS;
         cfg_ff.start_delay <= RST_START_DELAY;
         cfg_ff.period      <= RST_REPEAT_PERIOD;
         cfg_ff.long_time   <= RST_LONG_TIME;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REPEAT_BUTTONS: rep_buttons_ff     <= csr_wdata[6:0];
            CSR_START_DELAY:    cfg_ff.start_delay <= csr_wdata;
            CSR_REPEAT_PERIOD:  cfg_ff.period      <= csr_wdata;
            CSR_LONG_TIME:      cfg_ff.long_time   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake between the two stages
   assign rsp_fire   = rsp_valid & rsp_ready;
   assign batch_free = ~busy_ff | (rsp_fire & rsp_last);
   assign move       = in_valid_ff & batch_free;
   assign req_ready  = ~in_valid_ff | move;

   // Capture an input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_func_ff   <= req_func;
         in_levels_ff <= NUM_BUTTONS'(req_pressed_now);
         in_now_ff    <= TIME_BITS'(req_now_ms);
      end
   end

   // Evaluate every button in parallel
   assign poll     = (in_func_ff == FUNC_POLL);
   assign rep_mask = NUM_BUTTONS'(rep_buttons_ff);

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
      bevg_button #(
         .TIME_BITS (TIME_BITS)
      ) u_btn (
         .clock  (clock),
         .reset  (reset),
         .commit (move),
         .poll   (poll),
         .level  (in_levels_ff[g]),
         .rep_en (rep_mask[g]),
         .now    (in_now_ff),
         .cfg    (cfg_ff),
         .evt    (evt[g])
      );
      assign fire_vec[g] = evt[g].fire;
      assign act_vec[g]  = evt[g].activity;
   end

   // Update activity time and idle figure
   always_comb begin
      last_act_in = (|act_vec) ? in_now_ff : last_act_ff;
      idle_calc   = in_now_ff - last_act_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_act_ff <= '0;
      end else if (move) begin
         last_act_ff <= last_act_in;
      end
   end

   // Pick the lowest pending event
   always_comb begin
      first_hot = mask_ff & (~mask_ff + NUM_BUTTONS'(1));
      mask_rest = mask_ff & ~first_hot;
      sel_idx   = '0;
      sel_kind  = EV_PRESS;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (first_hot[i]) begin
            sel_idx  = IDX_W'(i);
            sel_kind = kind_ff[i];
         end
      end
   end

   // Load or drain the result register
   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      if (move) begin
         busy_in = 1'b1;
         mask_in = fire_vec;
      end else if (rsp_fire) begin
         busy_in = ~rsp_last;
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (move) begin
         idle_ff <= 32'(idle_calc);
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            kind_ff[i] <= evt[i].kind;
         end
      end
   end

   // Drive the result beat
   assign rsp_valid        = busy_ff;
   assign rsp_has_event    = |mask_ff;
   assign rsp_button_index = 3'(sel_idx);
   assign rsp_event_kind   = sel_kind;
   assign rsp_idle_time    = idle_ff;
   assign rsp_last         = ~(|mask_rest);

`ifndef SYNTHESIS
   // A beat without an event closes its item
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_event |-> rsp_last)
      else $error("empty result beat not marked last");

   // After a taken non-final beat the batch continues with an event
   a_batch_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_valid && rsp_has_event)
      else $error("event batch cut short");

   // A blocked input register keeps its item
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !batch_free |=> in_valid_ff && $stable(in_now_ff)
                                     && $stable(in_levels_ff))
      else $error("input item lost while result register busy");

   // Idle time is stable across one item's beats
   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> $stable(rsp_idle_time))
      else $error("idle time changed within one item");
`endif

endmodule

@@ hdl/bevg_button.sv @@
// ----------------------------------------------------------------------------
// bevg_button
// State and event decision of one button: level history, press start,
// last repeat and long-press flag; updated when the item is committed.
// ----------------------------------------------------------------------------
module bevg_button #(
   parameter int TIME_BITS = bevg_pkg::BEVG_TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   commit,
   input  logic                   poll,
   input  logic                   level,
   input  logic                   rep_en,
   input  logic [TIME_BITS-1:0]   now,
   input  bevg_pkg::thr_cfg_type  cfg,
   output bevg_pkg::btn_evt_type  evt
);
   import bevg_pkg::*;

   logic                 prev_ff,    prev_in;
   logic [TIME_BITS-1:0] start_ff,   start_in;
   logic [TIME_BITS-1:0] last_rep_ff, last_rep_in;
   logic                 long_done_ff, long_done_in;

   logic                 press, held, rel, rep, lng;
   logic [TIME_BITS-1:0] since_rep, since_press, rep_thr, long_thr;

   // Decide the event for this button
   always_comb begin
      since_rep   = now - last_rep_ff;
      since_press = now - start_ff;
      rep_thr     = (last_rep_ff == start_ff) ? TIME_BITS'(cfg.start_delay)
                                              : TIME_BITS'(cfg.period);
      long_thr    = TIME_BITS'(cfg.long_time);

      press = poll &  level & ~prev_ff;
      held  = poll &  level &  prev_ff;
      rel   = poll & ~level &  prev_ff;
      rep   = held &  rep_en & (since_rep >= rep_thr);
      lng   = held & ~rep_en & ~long_done_ff & (since_press >= long_thr);

      evt.fire     = press | rep | lng | rel;
      evt.activity = press | rep | rel;
      if (press) begin
         evt.kind = EV_PRESS;
      end else if (rep) begin
         evt.kind = EV_REPEAT;
      end else if (lng) begin
         evt.kind = EV_LONG;
      end else begin
         evt.kind = EV_RELEASE;
      end

      // Next state, taken only on commit
      prev_in      = level;
      start_in     = press ? now : start_ff;
      last_rep_in  = (press | rep) ? now : last_rep_ff;
      long_done_in = press ? 1'b0 : (lng ? 1'b1 : long_done_ff);
   end

   // Hold state until the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b0;
         start_ff     <= '0;
         last_rep_ff  <= '0;
         long_done_ff <= 1'b0;
      end else if (commit) begin
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         last_rep_ff  <= last_rep_in;
         long_done_ff <= long_done_in;
      end
   end

endmodule
